// ----- rtl/lfb_pkg.sv -----
// Package of the likelihood field builder: payload structs, operation and
// status codes, and the command and result structs between its modules.
// No dependencies.
`default_nettype none

package lfb_pkg;

  localparam int unsigned CFG_W     = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LIK_W     = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_W-1:0]     MAP_SIDE_RESET = 9'd256;

  // Operation codes of an input item.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Status codes of a result item.
  localparam logic [1:0] ST_BUILD_DONE = 2'd0;
  localparam logic [1:0] ST_READ_OK    = 2'd1;
  localparam logic [1:0] ST_READ_OUT   = 2'd2;

  // Occupancy byte that marks a cell as occupied.
  localparam logic [7:0] OCC_CODE = 8'd100;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] cell_value;
  } lfb_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [LIK_W-1:0] likelihood;
  } lfb_out_t;

  // Commands from the sequencer to the datapath, valid for one cycle.
  typedef struct packed {
    logic       occ_wr;
    logic       occ_bit;
    logic       gap_fwd;
    logic       gap_bwd;
    logic       gap_acc;
    logic       first;
    logic       sar_init;
    logic       sar_step;
    logic [2:0] sar_bit;
    logic       lik_wr;
    logic       lik_zero;
  } lfb_cmd_t;

  // Result request from the sequencer to the output register.
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic       use_data;
  } lfb_emit_t;

endpackage

`default_nettype wire

// ----- rtl/lfb_datapath.sv -----
// Datapath of the likelihood field builder: occupancy, row gap and
// likelihood memories, the row gap scan stage, the distance minimum and the
// cone value search. Depends on lfb_pkg.
`default_nettype none

module lfb_datapath
  import lfb_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 256,
  parameter int unsigned RADIUS   = 50
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lfb_cmd_t                     cmd_i,
  input  wire logic [$clog2(MAX_SIDE)-1:0]  cmd_x_i,
  input  wire logic [$clog2(MAX_SIDE)-1:0]  cmd_y_i,
  input  wire logic [$clog2(MAX_SIDE)-1:0]  cmd_r_i,
  output logic      [LIK_W-1:0]             rd_data_o
);

  localparam int unsigned C_W    = $clog2(MAX_SIDE);
  localparam int unsigned MEM_AW = 2 * C_W;
  localparam int unsigned DEPTH  = 1 << MEM_AW;
  localparam int unsigned G_W    = $clog2(RADIUS + 2);
  localparam int unsigned S_W    = $clog2(2 * RADIUS * RADIUS + 1);
  localparam logic [G_W-1:0] GAP_CAP = G_W'(RADIUS + 1);
  localparam logic [G_W-1:0] GAP_MAX = G_W'(RADIUS);
  localparam longint unsigned Denom = 64'd260100;

  typedef logic [255:0][S_W-1:0] thr_tbl_t;

  // Largest squared distance at which the cone still reaches level k.
  // Ties in the rounding go to the even level.
  function automatic thr_tbl_t build_thr();
    thr_tbl_t          tbl;
    longint unsigned   a;
    longint unsigned   a2;
    longint unsigned   q;
    tbl    = '0;
    tbl[0] = '1;
    for (int k = 1; k < 256; k++) begin
      a  = longint'(RADIUS) * longint'(511 - 2 * k);
      a2 = a * a;
      if (k[0] == 1'b0) begin
        q = a2 / Denom;
      end else begin
        q = (a2 - 64'd1) / Denom;
      end
      tbl[k] = S_W'(q);
    end
    return tbl;
  endfunction

  localparam thr_tbl_t THR = build_thr();

  logic             occ_mem [DEPTH];
  logic [G_W-1:0]   gap_mem [DEPTH];
  logic [LIK_W-1:0] lik_mem [DEPTH];

  logic [MEM_AW-1:0] cmd_addr;
  logic [MEM_AW-1:0] gap_rd_addr;
  logic [MEM_AW-1:0] s2_addr;

  logic             occ_rd_q;
  logic [G_W-1:0]   gap_rd_q;
  logic [LIK_W-1:0] lik_rd_q;

  // Second stage of the scan pipeline.
  logic           s2_fwd_q, s2_bwd_q, s2_acc_q, s2_first_q;
  logic [C_W-1:0] s2_x_q, s2_y_q, s2_r_q;

  logic [G_W-1:0]   run_q, run_d;
  logic [G_W-1:0]   run_base;
  logic             gap_we;
  logic [G_W-1:0]   gap_wdata;
  logic [C_W-1:0]   ady;
  logic [S_W-1:0]   g_ext, dy_ext, dist_sq;
  logic [S_W-1:0]   min_q, min_d, min_base;
  logic [LIK_W-1:0] sar_q, sar_d, trial;

  assign cmd_addr    = {cmd_y_i, cmd_x_i};
  assign gap_rd_addr = cmd_i.gap_acc ? {cmd_r_i, cmd_x_i} : {cmd_y_i, cmd_x_i};
  assign s2_addr     = {s2_y_q, s2_x_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.occ_wr) begin
      occ_mem[cmd_addr] <= cmd_i.occ_bit;
    end
    occ_rd_q <= occ_mem[cmd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (gap_we) begin
      gap_mem[s2_addr] <= gap_wdata;
    end
    gap_rd_q <= gap_mem[gap_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lik_wr) begin
      lik_mem[cmd_addr] <= cmd_i.lik_zero ? '0 : sar_q;
    end
    lik_rd_q <= lik_mem[cmd_addr];
  end

  assign rd_data_o = lik_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_fwd_q   <= 1'b0;
      s2_bwd_q   <= 1'b0;
      s2_acc_q   <= 1'b0;
      s2_first_q <= 1'b0;
    end else begin
      s2_fwd_q   <= cmd_i.gap_fwd;
      s2_bwd_q   <= cmd_i.gap_bwd;
      s2_acc_q   <= cmd_i.gap_acc;
      s2_first_q <= cmd_i.first;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_x_q <= cmd_x_i;
    s2_y_q <= cmd_y_i;
    s2_r_q <= cmd_r_i;
  end

  // Horizontal distance to the nearest occupied cell, capped one past the
  // cone radius. The backward pass keeps the smaller of both directions.
  always_comb begin
    run_base = s2_first_q ? GAP_CAP : run_q;
    if (occ_rd_q) begin
      run_d = '0;
    end else if (run_base < GAP_CAP) begin
      run_d = run_base + G_W'(1);
    end else begin
      run_d = run_base;
    end
    gap_we    = s2_fwd_q || s2_bwd_q;
    gap_wdata = (s2_bwd_q && (gap_rd_q < run_d)) ? gap_rd_q : run_d;
  end

  always_ff @(posedge clk_i) begin
    if (gap_we) begin
      run_q <= run_d;
    end
  end

  // Squared distance to the nearest occupied cell seen in this column window.
  always_comb begin
    ady      = (s2_r_q >= s2_y_q) ? (s2_r_q - s2_y_q) : (s2_y_q - s2_r_q);
    g_ext    = S_W'(gap_rd_q);
    dy_ext   = S_W'(ady);
    dist_sq  = (g_ext * g_ext) + (dy_ext * dy_ext);
    min_base = s2_first_q ? '1 : min_q;
    min_d    = min_q;
    if (s2_acc_q) begin
      min_d = ((gap_rd_q <= GAP_MAX) && (dist_sq < min_base)) ? dist_sq : min_base;
    end
  end

  // The cone falls monotonically with distance, so its level is found one
  // bit per cycle against the threshold table.
  always_comb begin
    trial = sar_q | (LIK_W'(1) << cmd_i.sar_bit);
    sar_d = sar_q;
    if (cmd_i.sar_init) begin
      sar_d = '0;
    end else if (cmd_i.sar_step && (min_q <= THR[trial])) begin
      sar_d = trial;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q <= min_d;
    sar_q <= sar_d;
  end

endmodule

`default_nettype wire

// ----- rtl/lfb_ctrl.sv -----
// Sequencer of the likelihood field builder: input handshake, load and read
// handling, and the row scan and cell walk of a build. Depends on lfb_pkg.
`default_nettype none

module lfb_ctrl
  import lfb_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 256,
  parameter int unsigned RADIUS   = 50
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          in_valid_i,
  input  wire lfb_in_t                                       in_i,
  output logic                                               in_stall_o,
  input  wire logic                                          out_busy_i,
  input  wire logic [(($clog2(MAX_SIDE+1) > 9) ? $clog2(MAX_SIDE+1) : 9)-1:0] eff_w_i,
  input  wire logic [(($clog2(MAX_SIDE+1) > 9) ? $clog2(MAX_SIDE+1) : 9)-1:0] eff_h_i,
  output lfb_cmd_t                                           cmd_o,
  output logic      [$clog2(MAX_SIDE)-1:0]                   cmd_x_o,
  output logic      [$clog2(MAX_SIDE)-1:0]                   cmd_y_o,
  output logic      [$clog2(MAX_SIDE)-1:0]                   cmd_r_o,
  output lfb_emit_t                                          emit_o
);

  localparam int unsigned C_W   = $clog2(MAX_SIDE);
  localparam int unsigned DIM_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned EXT_W = (DIM_W > 9) ? DIM_W : 9;
  localparam logic [EXT_W-1:0] SIDE_M1 = EXT_W'(MAX_SIDE - 1);
  localparam logic [EXT_W-1:0] RAD     = EXT_W'(RADIUS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_READ   = 4'd1;
  localparam logic [3:0] S_P1_FWD = 4'd2;
  localparam logic [3:0] S_P1_GAP = 4'd3;
  localparam logic [3:0] S_P1_BWD = 4'd4;
  localparam logic [3:0] S_P1_END = 4'd5;
  localparam logic [3:0] S_P2_SET = 4'd6;
  localparam logic [3:0] S_P2_ACC = 4'd7;
  localparam logic [3:0] S_P2_DRN = 4'd8;
  localparam logic [3:0] S_P2_SAR = 4'd9;
  localparam logic [3:0] S_P2_WR  = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0]       state_q, state_d;
  logic [EXT_W-1:0] x_q, x_d, y_q, y_d, r_q, r_d, r_hi_q, r_hi_d;
  logic [2:0]       bit_q, bit_d;
  logic             first_q, first_d;
  logic             inmap_q, inmap_d;
  logic             rd_inside_q, rd_inside_d;
  logic             built_q, built_d;

  logic             accept;
  logic             cell_in_map;
  logic [EXT_W-1:0] col_ext, row_ext;
  logic [EXT_W-1:0] w_m1, h_m1;
  logic [EXT_W-1:0] r_lo, r_hi, y_plus;

  assign in_stall_o = (state_q != S_IDLE) || out_busy_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign col_ext     = EXT_W'(in_i.col);
  assign row_ext     = EXT_W'(in_i.row);
  assign cell_in_map = (col_ext < eff_w_i) && (row_ext < eff_h_i);
  assign w_m1        = eff_w_i - EXT_W'(1);
  assign h_m1        = eff_h_i - EXT_W'(1);

  // Rows of the cone window around the current cell, clipped to the map.
  assign r_lo   = (y_q >= RAD) ? (y_q - RAD) : '0;
  assign y_plus = y_q + RAD;
  assign r_hi   = (y_plus > h_m1) ? h_m1 : y_plus;

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    r_d         = r_q;
    r_hi_d      = r_hi_q;
    bit_d       = bit_q;
    first_d     = first_q;
    inmap_d     = inmap_q;
    rd_inside_d = rd_inside_q;
    built_d     = built_q;
    cmd_o       = '0;
    cmd_x_o     = x_q[C_W-1:0];
    cmd_y_o     = y_q[C_W-1:0];
    cmd_r_o     = r_q[C_W-1:0];
    emit_o      = '0;

    unique case (state_q)
      S_IDLE: begin
        cmd_x_o = col_ext[C_W-1:0];
        cmd_y_o = row_ext[C_W-1:0];
        if (accept) begin
          unique case (in_i.operation)
            OP_LOAD: begin
              cmd_o.occ_wr  = cell_in_map;
              cmd_o.occ_bit = (in_i.cell_value == OCC_CODE);
            end
            OP_BUILD: begin
              built_d = 1'b1;
              x_d     = '0;
              y_d     = '0;
              if ((eff_w_i == '0) || (eff_h_i == '0)) begin
                state_d = S_P2_SET;
              end else begin
                state_d = S_P1_FWD;
              end
            end
            OP_READ: begin
              rd_inside_d = cell_in_map;
              state_d     = S_READ;
            end
            default: begin
            end
          endcase
        end
      end

      S_READ: begin
        emit_o.valid    = 1'b1;
        emit_o.status   = rd_inside_q ? ST_READ_OK : ST_READ_OUT;
        emit_o.use_data = rd_inside_q && built_q;
        state_d         = S_IDLE;
      end

      S_P1_FWD: begin
        cmd_o.gap_fwd = 1'b1;
        cmd_o.first   = (x_q == '0);
        if (x_q == w_m1) begin
          state_d = S_P1_GAP;
        end else begin
          x_d = x_q + EXT_W'(1);
        end
      end

      // The last forward write of the row lands here, before the backward
      // pass reads that cell.
      S_P1_GAP: begin
        state_d = S_P1_BWD;
      end

      S_P1_BWD: begin
        cmd_o.gap_bwd = 1'b1;
        cmd_o.first   = (x_q == w_m1);
        if (x_q == '0) begin
          if (y_q == h_m1) begin
            y_d     = '0;
            state_d = S_P1_END;
          end else begin
            y_d     = y_q + EXT_W'(1);
            state_d = S_P1_FWD;
          end
        end else begin
          x_d = x_q - EXT_W'(1);
        end
      end

      S_P1_END: begin
        state_d = S_P2_SET;
      end

      S_P2_SET: begin
        inmap_d = (x_q < eff_w_i) && (y_q < eff_h_i);
        r_d     = r_lo;
        r_hi_d  = r_hi;
        first_d = 1'b1;
        state_d = inmap_d ? S_P2_ACC : S_P2_WR;
      end

      S_P2_ACC: begin
        cmd_o.gap_acc = 1'b1;
        cmd_o.first   = first_q;
        first_d       = 1'b0;
        if (r_q == r_hi_q) begin
          state_d = S_P2_DRN;
        end else begin
          r_d = r_q + EXT_W'(1);
        end
      end

      S_P2_DRN: begin
        cmd_o.sar_init = 1'b1;
        bit_d          = '1;
        state_d        = S_P2_SAR;
      end

      S_P2_SAR: begin
        cmd_o.sar_step = 1'b1;
        cmd_o.sar_bit  = bit_q;
        if (bit_q == '0) begin
          state_d = S_P2_WR;
        end else begin
          bit_d = bit_q - 3'd1;
        end
      end

      S_P2_WR: begin
        cmd_o.lik_wr   = 1'b1;
        cmd_o.lik_zero = !inmap_q;
        state_d        = S_P2_SET;
        if (x_q == SIDE_M1) begin
          x_d = '0;
          if (y_q == SIDE_M1) begin
            state_d = S_DONE;
          end else begin
            y_d = y_q + EXT_W'(1);
          end
        end else begin
          x_d = x_q + EXT_W'(1);
        end
      end

      S_DONE: begin
        if (!out_busy_i) begin
          emit_o.valid  = 1'b1;
          emit_o.status = ST_BUILD_DONE;
          state_d       = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      x_q         <= '0;
      y_q         <= '0;
      r_q         <= '0;
      r_hi_q      <= '0;
      bit_q       <= '0;
      first_q     <= 1'b0;
      inmap_q     <= 1'b0;
      rd_inside_q <= 1'b0;
      built_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      y_q         <= y_d;
      r_q         <= r_d;
      r_hi_q      <= r_hi_d;
      bit_q       <= bit_d;
      first_q     <= first_d;
      inmap_q     <= inmap_d;
      rd_inside_q <= rd_inside_d;
      built_q     <= built_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/likelihood_field_builder_unit.sv -----
// Top level of the likelihood field builder: configuration registers, the
// output register and the sequencer and datapath. Depends on lfb_pkg,
// lfb_ctrl and lfb_datapath.
//
// Usage. Input items arrive on in_valid_i/in_stall_o/in_i and results leave
// on out_valid_o/out_stall_i/out_o; a transfer happens at a rising edge with
// valid high and stall low. A load gives no result. A read passes through the
// read state, then its result is registered in the output register, with
// status read data valid or read outside map. A build first scans every map
// row forward and backward, then walks all MAX_SIDE*MAX_SIDE cells: a cell
// inside the map reads the row gap memory once per row of its clipped cone
// window (at most 2*RADIUS+1 rows), then searches the cone level one bit at
// a time and writes its likelihood; a cell outside is written with zero. That
// walk also clears the cells outside the map, so no clearing pass is needed;
// until the first build every read returns zero. The build-done result
// follows the walk. At reset the output register empties, the map size
// registers return to 256 and the occupancy memory holds no defined data. A
// stalled result waits in the output register, and while it waits the block
// takes no new item of any kind.
`default_nettype none

module likelihood_field_builder_unit
  import lfb_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 256,
  parameter int unsigned RADIUS   = 50
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire lfb_in_t              in_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output lfb_out_t                  out_o
);

  localparam int unsigned C_W   = $clog2(MAX_SIDE);
  localparam int unsigned DIM_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned EXT_W = (DIM_W > 9) ? DIM_W : 9;
  localparam logic [EXT_W-1:0] SIDE = EXT_W'(MAX_SIDE);

  logic [CFG_W-1:0] map_width_q, map_height_q;
  logic [EXT_W-1:0] eff_w, eff_h;

  logic       out_valid_q, out_valid_d;
  lfb_out_t   out_q, out_d;
  logic       out_busy;

  lfb_cmd_t         cmd;
  logic [C_W-1:0]   cmd_x, cmd_y, cmd_r;
  lfb_emit_t        emit;
  logic [LIK_W-1:0] rd_data;

  // Map size registers; sizes above MAX_SIDE act as MAX_SIDE.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= MAP_SIDE_RESET;
      map_height_q <= MAP_SIDE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAP_WIDTH:  map_width_q  <= cfg_wdata_i;
        REG_MAP_HEIGHT: map_height_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign eff_w = (EXT_W'(map_width_q) > SIDE) ? SIDE : EXT_W'(map_width_q);
  assign eff_h = (EXT_W'(map_height_q) > SIDE) ? SIDE : EXT_W'(map_height_q);

  // The output register is occupied for the next cycle when it holds a
  // result that the receiver stalls.
  assign out_busy = out_valid_q && out_stall_i;

  lfb_ctrl #(
    .MAX_SIDE (MAX_SIDE),
    .RADIUS   (RADIUS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .in_stall_o (in_stall_o),
    .out_busy_i (out_busy),
    .eff_w_i    (eff_w),
    .eff_h_i    (eff_h),
    .cmd_o      (cmd),
    .cmd_x_o    (cmd_x),
    .cmd_y_o    (cmd_y),
    .cmd_r_o    (cmd_r),
    .emit_o     (emit)
  );

  lfb_datapath #(
    .MAX_SIDE (MAX_SIDE),
    .RADIUS   (RADIUS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .cmd_x_i   (cmd_x),
    .cmd_y_i   (cmd_y),
    .cmd_r_i   (cmd_r),
    .rd_data_o (rd_data)
  );

  // The sequencer only requests a result when the register is free or is
  // being emptied in the same cycle.
  always_comb begin
    out_d = out_q;
    if (emit.valid) begin
      out_d.status     = emit.status;
      out_d.likelihood = emit.use_data ? rd_data : '0;
    end
    if (emit.valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ----- test/likelihood_field_builder_unit_tb.sv -----
// Self-checking testbench of likelihood_field_builder_unit: occupancy loads,
// likelihood builds and reads, checked against a predictor kept in this file.
// Depends on lfb_pkg and the RTL of the block; reads no files.

module likelihood_field_builder_unit_tb;
  import lfb_pkg::*;

  localparam int SIDE         = 256;
  localparam int CONE_RADIUS  = 50;
  localparam int CELLS        = SIDE * SIDE;
  // A row gap saturates one step beyond the cone, where the cone is zero anyway.
  localparam int GAP_CAP      = CONE_RADIUS + 1;
  // The cone peak of 255 doubled and squared; it scales the squared distance
  // so that rounding to nearest can be decided on integers alone.
  localparam longint PEAK2_SQ = 510 * 510;
  localparam int CLK_PERIOD   = 20;
  localparam int DRAIN_CYCLES = 8;
  localparam int unsigned LIMIT_CYCLES = 8_000_000;
  // The block owes at most two results at a time; this leaves ample room.
  localparam int unsigned OWED_DEPTH = 16;

  // The one operation code that the block has no use for.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Clock, reset and every input of the block start at known values.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  lfb_in_t              in_i        = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  lfb_out_t             out_o;

  likelihood_field_builder_unit #(
    .MAX_SIDE(SIDE),
    .RADIUS  (CONE_RADIUS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors the block: the two map size registers, the
  // occupancy grid, the likelihood grid and the constant cone table. The
  // loaded flags track which occupancy cells hold defined data, so that no
  // build is ever sent while a cell inside the map is still undefined.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] map_width  = MAP_SIDE_RESET;
  logic [CFG_W-1:0] map_height = MAP_SIDE_RESET;
  bit               occ_map    [CELLS];
  bit               loaded     [CELLS];
  bit [7:0]         lik_map    [CELLS];
  int unsigned      row_gap    [CELLS];
  bit [7:0]         cone_lut   [0:CONE_RADIUS][0:CONE_RADIUS];

  // Results that the block owes, oldest first, kept in a ring.
  lfb_out_t         owed_fifo [OWED_DEPTH];
  int unsigned      owed_head = 0;
  int unsigned      owed_tail = 0;
  lfb_out_t         oldest_owed;

  // Idling percentages of the current phase, for the sender and the receiver.
  int               sender_idle_pct = 0;
  int               receiver_stall_pct = 0;

  int               mismatch_count = 0;
  int               items_sent     = 0;
  int               builds_sent    = 0;
  int               reads_sent     = 0;
  int               results_checked = 0;

  // Cone level for a squared distance s: the largest k in 1..255 for which
  // 255*(1 - d/R) rounds to at least k, with ties going to the even level.
  function automatic bit [7:0] cone_level(longint s);
    longint lhs;
    longint rhs;
    int     k;
    int     level;
    bit     going;
    rhs   = PEAK2_SQ * s;
    level = 0;
    going = 1'b1;
    for (k = 1; k <= 255 && going; k++) begin
      lhs = longint'(CONE_RADIUS) * longint'(511 - 2 * k);
      lhs = lhs * lhs;
      if (lhs > rhs || (lhs == rhs && (k % 2) == 0)) begin
        level = k;
      end else begin
        going = 1'b0;
      end
    end
    return level[7:0];
  endfunction

  // A register above the largest side acts as the largest side.
  function automatic int unsigned side_in_use(logic [CFG_W-1:0] value);
    return (value > SIDE) ? SIDE : value;
  endfunction

  // Rebuild the likelihood grid for a w x h map. The cone falls with distance,
  // so for each cell only the nearest occupied cell of every row in the
  // window matters; that nearest distance comes from two sweeps per row.
  function automatic void rebuild_field(int unsigned w, int unsigned h);
    int unsigned idx;
    int unsigned x;
    int unsigned y;
    int unsigned run;
    int unsigned best;
    int unsigned g;
    int unsigned ady;
    int          r;
    int          dy;
    for (idx = 0; idx < CELLS; idx++) begin
      lik_map[idx] = '0;
    end
    for (y = 0; y < h; y++) begin
      run = GAP_CAP;
      for (x = 0; x < w; x++) begin
        if (occ_map[y * SIDE + x]) run = 0;
        else if (run < GAP_CAP) run++;
        row_gap[y * SIDE + x] = run;
      end
      run = GAP_CAP;
      for (x = w; x > 0; x--) begin
        if (occ_map[y * SIDE + x - 1]) run = 0;
        else if (run < GAP_CAP) run++;
        if (run < row_gap[y * SIDE + x - 1]) row_gap[y * SIDE + x - 1] = run;
      end
    end
    for (y = 0; y < h; y++) begin
      for (x = 0; x < w; x++) begin
        best = 0;
        for (dy = -CONE_RADIUS; dy <= CONE_RADIUS; dy++) begin
          r = int'(y) + dy;
          if (r >= 0 && r < int'(h)) begin
            g = row_gap[r * SIDE + x];
            ady = (dy < 0) ? -dy : dy;
            if (g <= CONE_RADIUS && cone_lut[g][ady] > best) best = cone_lut[g][ady];
          end
        end
        lik_map[y * SIDE + x] = best[7:0];
      end
    end
  endfunction

  function automatic int unsigned owed_count();
    return owed_tail - owed_head;
  endfunction

  function automatic void owe_result(lfb_out_t res);
    owed_fifo[owed_tail % OWED_DEPTH] = res;
    owed_tail++;
  endfunction

  function automatic lfb_out_t take_owed();
    lfb_out_t res;
    res = owed_fifo[owed_head % OWED_DEPTH];
    owed_head++;
    return res;
  endfunction

  // Apply one accepted item to the predictor and queue the result it owes.
  function automatic void predict_item(lfb_in_t item);
    int unsigned w;
    int unsigned h;
    int unsigned idx;
    bit          in_map;
    lfb_out_t    res;
    w      = side_in_use(map_width);
    h      = side_in_use(map_height);
    in_map = (item.col < w) && (item.row < h);
    idx    = int'(item.row) * SIDE + int'(item.col);
    case (item.operation)
      OP_LOAD: begin
        if (in_map) begin
          occ_map[idx] = (item.cell_value == OCC_CODE);
          loaded[idx]  = 1'b1;
        end
      end
      OP_BUILD: begin
        rebuild_field(w, h);
        res.status     = ST_BUILD_DONE;
        res.likelihood = '0;
        owe_result(res);
      end
      OP_READ: begin
        res.status     = in_map ? ST_READ_OK : ST_READ_OUT;
        res.likelihood = in_map ? lik_map[idx] : '0;
        owe_result(res);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: mismatch: %s", $time, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side. Every result transfer is checked against the oldest owed
  // result, and the stall for the next cycle is drawn at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_count() == 0) begin
        note_failure($sformatf("unexpected result: status %0d likelihood %0d",
                               out_o.status, out_o.likelihood));
      end else begin
        oldest_owed = take_owed();
        results_checked++;
        if (out_o.status !== oldest_owed.status)
          note_failure($sformatf("status: expected %0d, got %0d",
                                 oldest_owed.status, out_o.status));
        if (out_o.likelihood !== oldest_owed.likelihood)
          note_failure($sformatf("likelihood: expected %0d, got %0d",
                                 oldest_owed.likelihood, out_o.likelihood));
      end
    end
    out_stall_i <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------

  // Send one item: idle for a random number of cycles as the phase asks, then
  // hold it until the block takes it, and predict it at that edge.
  task automatic send_item(input logic [1:0] op, input int unsigned col,
                           input int unsigned row, input int unsigned cell_byte);
    lfb_in_t item;
    item.operation  = op;
    item.col        = col[7:0];
    item.row        = row[7:0];
    item.cell_value = cell_byte[7:0];
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= item;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    predict_item(item);
    if (op != OP_UNUSED) items_sent++;
    if (op == OP_BUILD) builds_sent++;
    if (op == OP_READ) reads_sent++;
  endtask

  // Let the block run dry: no item in flight, every owed result delivered,
  // and a few more cycles for a load that is still being written.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (owed_count() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Both map size registers are written back to back while the block is idle.
  task automatic set_map_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_MAP_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    map_width   = w;
    cfg_idx_i   <= REG_MAP_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    map_height  = h;
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  // Occupancy byte: the occupied code with the given chance, else any byte.
  function automatic int unsigned pick_cell_value(int occ_pct);
    return ($urandom_range(99) < occ_pct) ? int'(OCC_CODE) : $urandom_range(255);
  endfunction

  // A build reads every occupancy cell of the map, so each one that was never
  // written gets a load first.
  task automatic load_unwritten_cells(input int occ_pct);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    w = side_in_use(map_width);
    h = side_in_use(map_height);
    for (y = 0; y < h; y++) begin
      for (x = 0; x < w; x++) begin
        if (!loaded[y * SIDE + x]) send_item(OP_LOAD, x, y, pick_cell_value(occ_pct));
      end
    end
  endtask

  task automatic send_build();
    send_item(OP_BUILD, $urandom_range(255), $urandom_range(255), $urandom_range(255));
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reads before any build, the unused operation, a tiny map with occupied
  // corners, loads and reads outside the map, and bytes next to the code.
  task automatic test_directed();
    set_idling(0, 0);
    send_item(OP_READ, 0, 0, 0);
    send_item(OP_READ, 255, 255, 255);
    send_item(OP_UNUSED, 255, 255, 255);
    set_map_size(9'd4, 9'd3);
    send_item(OP_LOAD, 0, 0, OCC_CODE);
    send_item(OP_LOAD, 3, 2, OCC_CODE);
    send_item(OP_LOAD, 1, 0, 0);
    send_item(OP_LOAD, 2, 0, 255);
    send_item(OP_LOAD, 3, 0, 99);
    send_item(OP_LOAD, 0, 1, 101);
    // Outside the map these must leave no trace, even with the occupied code.
    send_item(OP_LOAD, 4, 0, OCC_CODE);
    send_item(OP_LOAD, 255, 255, OCC_CODE);
    load_unwritten_cells(0);
    send_build();
    send_item(OP_READ, 0, 0, 0);
    send_item(OP_READ, 3, 2, 0);
    send_item(OP_READ, 1, 1, 0);
    send_item(OP_READ, 3, 0, 0);
    send_item(OP_READ, 4, 0, 0);
    send_item(OP_READ, 0, 3, 0);
    send_item(OP_READ, 255, 255, 0);
  endtask

  // Register extremes: an empty map, a single row wider than the grid and a
  // single column taller than it. Each one gets a build and reads at its edges.
  task automatic test_map_extremes();
    int i;
    set_idling(36, 36);
    set_map_size(9'd0, 9'd0);
    send_item(OP_READ, 0, 0, 0);
    send_build();
    send_item(OP_READ, 0, 0, 0);
    // The empty build must still have cleared what the earlier build left.
    set_map_size(9'd4, 9'd3);
    send_item(OP_READ, 0, 0, 0);
    send_item(OP_READ, 3, 2, 0);

    set_map_size(9'd511, 9'd1);
    send_item(OP_LOAD, 0, 0, OCC_CODE);
    send_item(OP_LOAD, 255, 0, OCC_CODE);
    send_item(OP_LOAD, 128, 0, OCC_CODE);
    load_unwritten_cells(3);
    send_build();
    send_item(OP_READ, 0, 0, 0);
    send_item(OP_READ, 255, 0, 0);
    send_item(OP_READ, 0, 1, 0);
    for (i = 0; i < 16; i++) send_item(OP_READ, $urandom_range(255), 0, 0);

    set_map_size(9'd1, 9'd511);
    send_item(OP_LOAD, 0, 0, OCC_CODE);
    send_item(OP_LOAD, 0, 255, OCC_CODE);
    load_unwritten_cells(3);
    send_build();
    send_item(OP_READ, 0, 0, 0);
    send_item(OP_READ, 0, 255, 0);
    send_item(OP_READ, 1, 0, 0);
    for (i = 0; i < 16; i++) send_item(OP_READ, 0, $urandom_range(255), 0);
  endtask

  // Loads, reads and unused operations across the grid on a random map size, no build.
  // Reads lean toward the left columns, where the last build left a cone.
  task automatic random_traffic_phase(input int count);
    int i;
    int unsigned pick;
    if ($urandom_range(3) == 0) set_map_size(MAP_SIDE_RESET, MAP_SIDE_RESET);
    else set_map_size(CFG_W'($urandom_range(511)), CFG_W'($urandom_range(511)));
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_item(OP_LOAD, $urandom_range(255), $urandom_range(255), pick_cell_value(10));
      end else if (pick < 70) begin
        send_item(OP_READ, $urandom_range(255), $urandom_range(255), $urandom_range(255));
      end else if (pick < 95) begin
        send_item(OP_READ, $urandom_range(63), $urandom_range(255), $urandom_range(255));
      end else begin
        send_item(OP_UNUSED, $urandom_range(255), $urandom_range(255), $urandom_range(255));
      end
    end
  endtask

  // A well-formed sequence on a small random map: scattered loads, loads of
  // whatever is still undefined, a build, then mostly reads inside the map
  // mixed with reads anywhere, stray loads and unused operations.
  task automatic random_build_phase(input int count);
    int i;
    int unsigned w;
    int unsigned h;
    int unsigned pick;
    set_map_size(CFG_W'($urandom_range(16, 1)), CFG_W'($urandom_range(16, 1)));
    w = side_in_use(map_width);
    h = side_in_use(map_height);
    for (i = 0; i < 40; i++) begin
      send_item(OP_LOAD, $urandom_range(w - 1), $urandom_range(h - 1), pick_cell_value(12));
    end
    load_unwritten_cells(8);
    send_build();
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_item(OP_READ, $urandom_range(w - 1), $urandom_range(h - 1), $urandom_range(255));
      end else if (pick < 75) begin
        send_item(OP_READ, $urandom_range(255), $urandom_range(255), $urandom_range(255));
      end else if (pick < 92) begin
        send_item(OP_LOAD, $urandom_range(255), $urandom_range(255), pick_cell_value(12));
      end else begin
        send_item(OP_UNUSED, $urandom_range(255), $urandom_range(255), $urandom_range(255));
      end
    end
  endtask

  // One phase per idling pattern. Builds walk the whole grid and are slow,
  // so the phase without idling carries loads, reads and unused operations, no build.
  task automatic test_random_phases();
    set_idling(0, 0);
    random_traffic_phase(80);
    set_idling(83, 0);
    random_build_phase(50);
    set_idling(0, 83);
    random_build_phase(50);
    set_idling(36, 36);
    random_build_phase(50);
  endtask

  initial begin
    int i;
    int j;
    for (i = 0; i <= CONE_RADIUS; i++) begin
      for (j = 0; j <= CONE_RADIUS; j++) begin
        cone_lut[i][j] = cone_level(longint'(i * i + j * j));
      end
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_map_extremes();
    test_random_phases();
    wait_idle();

    $display("Covered %0d items: %0d builds and %0d reads, %0d results checked,",
             items_sent, builds_sent, reads_sent, results_checked);
    $display("over empty, single row, single column and small random maps.");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total.", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run, builds included.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Timed out with %0d results still owed.", owed_count());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
